// ----- hw/rtl/csc_pkg.sv -----
// shared constants, region codes and stage control type for the clearance core
// no dependencies; compiled first
`default_nettype none

package csc_pkg;

    // default field widths
    localparam int CSC_COORD_WIDTH = 24;
    localparam int CSC_FRAC_BITS   = 16;

    // fraction bits of the projection parameter
    localparam int CSC_LAMBDA_BITS = 24;

    // clamp region codes
    typedef logic [1:0] t_region;
    localparam t_region RGN_BASE   = 2'd0;
    localparam t_region RGN_INSIDE = 2'd1;
    localparam t_region RGN_END    = 2'd2;

    // advance enable and beat valid handed into each section
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/csc_if.sv -----
// valid/ready channel interfaces for query and result beats
// depends on csc_pkg for default widths
`default_nettype none

interface csc_in_if #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH,
    parameter int FRAC_BITS   = csc_pkg::CSC_FRAC_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] base_x;
    logic signed [COORD_WIDTH-1:0] base_y;
    logic signed [COORD_WIDTH-1:0] base_z;
    logic signed [FRAC_BITS+1:0]   axis_x;
    logic signed [FRAC_BITS+1:0]   axis_y;
    logic signed [FRAC_BITS+1:0]   axis_z;
    logic        [COORD_WIDTH-2:0] axis_length;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic        [COORD_WIDTH-2:0] radius_a;
    logic        [COORD_WIDTH-2:0] radius_b;

    modport source (
        output valid, base_x, base_y, base_z, axis_x, axis_y, axis_z, axis_length,
               point_x, point_y, point_z, radius_a, radius_b,
        input  ready
    );
    modport sink (
        input  valid, base_x, base_y, base_z, axis_x, axis_y, axis_z, axis_length,
               point_x, point_y, point_z, radius_a, radius_b,
        output ready
    );
endinterface

interface csc_out_if #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] clearance;
    logic        [1:0]             region;
    logic                          saturated;

    modport source (output valid, clearance, region, saturated, input ready);
    modport sink   (input  valid, clearance, region, saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/csc_proj.sv -----
// segment direction, offset and projection dot products, three stages
// depends on csc_pkg
`default_nettype none

module csc_proj #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH,
    parameter int FRAC_BITS   = csc_pkg::CSC_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  csc_pkg::t_stage_ctl             i_ctl,
    input  logic signed [COORD_WIDTH-1:0]   i_base [3],
    input  logic signed [FRAC_BITS+1:0]     i_axis [3],
    input  logic        [COORD_WIDTH-2:0]   i_len,
    input  logic signed [COORD_WIDTH-1:0]   i_point [3],
    input  logic        [COORD_WIDTH-2:0]   i_ra,
    input  logic        [COORD_WIDTH-2:0]   i_rb,
    output logic                            o_valid,
    output logic signed [COORD_WIDTH+1:0]   o_d [3],
    output logic signed [COORD_WIDTH:0]     o_v [3],
    output logic signed [2*COORD_WIDTH+4:0] o_dot,
    output logic signed [2*COORD_WIDTH+4:0] o_dd,
    output csc_pkg::t_region                o_region,
    output logic        [COORD_WIDTH-2:0]   o_ra,
    output logic        [COORD_WIDTH-2:0]   o_rb
);
    import csc_pkg::*;

    localparam int PW   = COORD_WIDTH + FRAC_BITS + 2;
    localparam int DW   = PW - FRAC_BITS;
    localparam int VW   = COORD_WIDTH + 1;
    localparam int PDW  = VW + DW;
    localparam int DOTW = PDW + 2;

    logic signed [PW-1:0]    n_prod [3];
    logic signed [DW-1:0]    r_a_d [3];
    logic signed [VW-1:0]    r_a_v [3];
    logic [COORD_WIDTH-2:0]  r_a_ra, r_a_rb;
    logic                    r_a_vld;
    logic signed [PDW-1:0]   r_b_pvd [3];
    logic signed [2*DW-1:0]  r_b_pdd [3];
    logic signed [DW-1:0]    r_b_d [3];
    logic signed [VW-1:0]    r_b_v [3];
    logic [COORD_WIDTH-2:0]  r_b_ra, r_b_rb;
    logic                    r_b_vld;
    logic signed [DOTW-1:0]  n_dot, n_dd;
    t_region                 n_region;
    logic signed [DOTW-1:0]  r_c_dot, r_c_dd;
    t_region                 r_c_region;
    logic signed [DW-1:0]    r_c_d [3];
    logic signed [VW-1:0]    r_c_v [3];
    logic [COORD_WIDTH-2:0]  r_c_ra, r_c_rb;
    logic                    r_c_vld;

    // length times axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = $signed({1'b0, i_len}) * i_axis[i];
        end
    end

    // stage a: direction offset and centre offset
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_d[i] <= n_prod[i][PW-1:FRAC_BITS];
                r_a_v[i] <= $signed({i_point[i][COORD_WIDTH-1], i_point[i]})
                          - $signed({i_base[i][COORD_WIDTH-1], i_base[i]});
            end
            r_a_ra <= i_ra;
            r_a_rb <= i_rb;
        end
    end

    // stage b: component products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_pvd[i] <= r_a_v[i] * r_a_d[i];
                r_b_pdd[i] <= r_a_d[i] * r_a_d[i];
                r_b_d[i]   <= r_a_d[i];
                r_b_v[i]   <= r_a_v[i];
            end
            r_b_ra <= r_a_ra;
            r_b_rb <= r_a_rb;
        end
    end

    // sums and clamp decision: base when dd is zero or dot is at or below zero (sign bit or zero)
    always_comb begin
        n_dot = DOTW'(r_b_pvd[0]) + DOTW'(r_b_pvd[1]) + DOTW'(r_b_pvd[2]);
        n_dd  = DOTW'(r_b_pdd[0]) + DOTW'(r_b_pdd[1]) + DOTW'(r_b_pdd[2]);
        if (n_dd == '0 || n_dot[DOTW-1] || n_dot == '0) begin
            n_region = RGN_BASE;
        end else if (n_dot >= n_dd) begin
            n_region = RGN_END;
        end else begin
            n_region = RGN_INSIDE;
        end
    end

    // stage c
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_c_dot    <= n_dot;
            r_c_dd     <= n_dd;
            r_c_region <= n_region;
            for (int i = 0; i < 3; i++) begin
                r_c_d[i] <= r_b_d[i];
                r_c_v[i] <= r_b_v[i];
            end
            r_c_ra <= r_b_ra;
            r_c_rb <= r_b_rb;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_vld <= i_ctl.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    assign o_valid  = r_c_vld;
    assign o_d      = r_c_d;
    assign o_v      = r_c_v;
    assign o_dot    = r_c_dot;
    assign o_dd     = r_c_dd;
    assign o_region = r_c_region;
    assign o_ra     = r_c_ra;
    assign o_rb     = r_c_rb;

endmodule

`default_nettype wire

// ----- hw/rtl/csc_div.sv -----
// pipelined restoring divider for the projection parameter, one quotient bit per stage
// depends on csc_pkg
`default_nettype none

module csc_div #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csc_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [COORD_WIDTH+1:0]       i_d [3],
    input  logic signed [COORD_WIDTH:0]         i_v [3],
    input  logic signed [2*COORD_WIDTH+4:0]     i_dot,
    input  logic signed [2*COORD_WIDTH+4:0]     i_dd,
    input  csc_pkg::t_region                    i_region,
    input  logic        [COORD_WIDTH-2:0]       i_ra,
    input  logic        [COORD_WIDTH-2:0]       i_rb,
    output logic                                o_valid,
    output logic        [csc_pkg::CSC_LAMBDA_BITS-1:0] o_t,
    output logic signed [COORD_WIDTH+1:0]       o_d [3],
    output logic signed [COORD_WIDTH:0]         o_v [3],
    output csc_pkg::t_region                    o_region,
    output logic        [COORD_WIDTH-2:0]       o_ra,
    output logic        [COORD_WIDTH-2:0]       o_rb
);
    import csc_pkg::*;

    localparam int DW = COORD_WIDTH + 2;
    localparam int VW = COORD_WIDTH + 1;
    localparam int RW = 2 * COORD_WIDTH + 5;
    localparam int TW = CSC_LAMBDA_BITS;

    logic [RW-1:0]          r_rem [0:TW];
    logic [RW-1:0]          r_den [0:TW];
    logic [TW-1:0]          r_q   [0:TW];
    logic signed [DW-1:0]   r_d   [0:TW][0:2];
    logic signed [VW-1:0]   r_v   [0:TW][0:2];
    t_region                r_rgn [0:TW];
    logic [COORD_WIDTH-2:0] r_ra  [0:TW];
    logic [COORD_WIDTH-2:0] r_rb  [0:TW];
    logic                   r_vld [0:TW];

    // one restoring step: shifted remainder and quotient bit
    function automatic logic [RW:0] div_step(input logic [RW-1:0] rem,
                                             input logic [RW-1:0] den);
        logic [RW:0] sh;
        logic [RW:0] df;
        sh = {rem, 1'b0};
        df = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {df[RW-1:0], 1'b1};
        end
        return {sh[RW-1:0], 1'b0};
    endfunction

    // load stage then one step per stage
    always_ff @(posedge i_clk) begin
        logic [RW:0] st;
        if (i_ctl.en) begin
            r_rem[0] <= i_dot[RW-1:0];
            r_den[0] <= i_dd[RW-1:0];
            r_q[0]   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_d[0][i] <= i_d[i];
                r_v[0][i] <= i_v[i];
            end
            r_rgn[0] <= i_region;
            r_ra[0]  <= i_ra;
            r_rb[0]  <= i_rb;
            for (int k = 1; k <= TW; k++) begin
                st = div_step(r_rem[k-1], r_den[k-1]);
                r_rem[k] <= st[RW:1];
                r_q[k]   <= {r_q[k-1][TW-2:0], st[0]};
                r_den[k] <= r_den[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_d[k][i] <= r_d[k-1][i];
                    r_v[k][i] <= r_v[k-1][i];
                end
                r_rgn[k] <= r_rgn[k-1];
                r_ra[k]  <= r_ra[k-1];
                r_rb[k]  <= r_rb[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= TW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.valid;
            for (int k = 1; k <= TW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid  = r_vld[TW];
    assign o_t      = r_q[TW];
    assign o_d      = r_d[TW];
    assign o_v      = r_v[TW];
    assign o_region = r_rgn[TW];
    assign o_ra     = r_ra[TW];
    assign o_rb     = r_rb[TW];

endmodule

`default_nettype wire

// ----- hw/rtl/csc_dist.sv -----
// closest point offset, squared norm, pipelined square root and saturated clearance
// depends on csc_pkg
`default_nettype none

module csc_dist #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csc_pkg::t_stage_ctl                 i_ctl,
    input  logic        [csc_pkg::CSC_LAMBDA_BITS-1:0] i_t,
    input  logic signed [COORD_WIDTH+1:0]       i_d [3],
    input  logic signed [COORD_WIDTH:0]         i_v [3],
    input  csc_pkg::t_region                    i_region,
    input  logic        [COORD_WIDTH-2:0]       i_ra,
    input  logic        [COORD_WIDTH-2:0]       i_rb,
    output logic                                o_valid,
    output logic signed [COORD_WIDTH-1:0]       o_clearance,
    output csc_pkg::t_region                    o_region,
    output logic                                o_saturated
);
    import csc_pkg::*;

    localparam int TW   = CSC_LAMBDA_BITS;
    localparam int DW   = COORD_WIDTH + 2;
    localparam int VW   = COORD_WIDTH + 1;
    localparam int QW   = DW + TW + 1;
    localparam int DFW  = DW + 2;
    localparam int SQW  = 2 * DFW + 2;
    localparam int RTW  = SQW / 2;
    localparam int RMW  = RTW + 3;
    localparam int CLW  = RTW + 2;
    localparam logic signed [CLW-1:0] CL_MAX = {{(CLW-COORD_WIDTH+1){1'b0}},
                                                {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [CLW-1:0] CL_MIN = {{(CLW-COORD_WIDTH+1){1'b1}},
                                                {(COORD_WIDTH-1){1'b0}}};

    logic signed [QW-1:0]   r_p_q [3];
    logic signed [DW-1:0]   r_p_d [3];
    logic signed [VW-1:0]   r_p_v [3];
    t_region                r_p_rgn;
    logic [COORD_WIDTH-2:0] r_p_ra, r_p_rb;
    logic                   r_p_vld;

    logic signed [DFW-1:0]  n_diff [3];
    logic signed [DFW-1:0]  r_f_diff [3];
    t_region                r_f_rgn;
    logic [COORD_WIDTH-2:0] r_f_ra, r_f_rb;
    logic                   r_f_vld;

    logic [DFW-1:0]         n_mag [3];
    logic [2*DFW-1:0]       r_s_sq [3];
    t_region                r_s_rgn;
    logic [COORD_WIDTH-2:0] r_s_ra, r_s_rb;
    logic                   r_s_vld;

    logic [SQW-1:0]         r_n    [0:RTW];
    logic [RMW-1:0]         r_rem  [0:RTW];
    logic [RTW-1:0]         r_root [0:RTW];
    t_region                r_rgn  [0:RTW];
    logic [COORD_WIDTH-2:0] r_ra   [0:RTW];
    logic [COORD_WIDTH-2:0] r_rb   [0:RTW];
    logic                   r_vld  [0:RTW];

    logic signed [CLW-1:0]  n_cl;
    logic signed [COORD_WIDTH-1:0] r_o_cl;
    t_region                r_o_rgn;
    logic                   r_o_sat;
    logic                   r_o_vld;

    // stage p: direction scaled by the projection parameter
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_p_q[i] <= i_d[i] * $signed({1'b0, i_t});
                r_p_d[i] <= i_d[i];
                r_p_v[i] <= i_v[i];
            end
            r_p_rgn <= i_region;
            r_p_ra  <= i_ra;
            r_p_rb  <= i_rb;
        end
    end

    // offset from the closest point on the segment
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_p_rgn)
                RGN_INSIDE: n_diff[i] = DFW'(r_p_v[i]) - DFW'($signed(r_p_q[i][QW-1:TW]));
                RGN_END:    n_diff[i] = DFW'(r_p_v[i]) - DFW'(r_p_d[i]);
                default:    n_diff[i] = DFW'(r_p_v[i]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_f_diff <= n_diff;
            r_f_rgn  <= r_p_rgn;
            r_f_ra   <= r_p_ra;
            r_f_rb   <= r_p_rb;
        end
    end

    // magnitudes and squares
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = r_f_diff[i][DFW-1] ? DFW'(-r_f_diff[i]) : DFW'(r_f_diff[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_s_sq[i] <= n_mag[i] * n_mag[i];
            end
            r_s_rgn <= r_f_rgn;
            r_s_ra  <= r_f_ra;
            r_s_rb  <= r_f_rb;
        end
    end

    // square root: sum loads stage 0, one root bit per stage
    always_ff @(posedge i_clk) begin
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        if (i_ctl.en) begin
            r_n[0]    <= SQW'(r_s_sq[0]) + SQW'(r_s_sq[1]) + SQW'(r_s_sq[2]);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rgn[0]  <= r_s_rgn;
            r_ra[0]   <= r_s_ra;
            r_rb[0]   <= r_s_rb;
            for (int k = 1; k <= RTW; k++) begin
                rem2  = {r_rem[k-1][RMW-3:0], r_n[k-1][SQW-1:SQW-2]};
                trial = {1'b0, r_root[k-1], 2'b01};
                if (rem2 >= trial) begin
                    r_rem[k]  <= rem2 - trial;
                    r_root[k] <= {r_root[k-1][RTW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem2;
                    r_root[k] <= {r_root[k-1][RTW-2:0], 1'b0};
                end
                r_n[k]   <= {r_n[k-1][SQW-3:0], 2'b00};
                r_rgn[k] <= r_rgn[k-1];
                r_ra[k]  <= r_ra[k-1];
                r_rb[k]  <= r_rb[k-1];
            end
        end
    end

    // clearance and saturation
    always_comb begin
        n_cl = $signed({2'b00, r_root[RTW]})
             - $signed({{(CLW-COORD_WIDTH+1){1'b0}}, r_ra[RTW]})
             - $signed({{(CLW-COORD_WIDTH+1){1'b0}}, r_rb[RTW]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_o_rgn <= r_rgn[RTW];
            if (n_cl > CL_MAX) begin
                r_o_cl  <= CL_MAX[COORD_WIDTH-1:0];
                r_o_sat <= 1'b1;
            end else if (n_cl < CL_MIN) begin
                r_o_cl  <= CL_MIN[COORD_WIDTH-1:0];
                r_o_sat <= 1'b1;
            end else begin
                r_o_cl  <= n_cl[COORD_WIDTH-1:0];
                r_o_sat <= 1'b0;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k <= RTW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_ctl.en) begin
            r_p_vld  <= i_ctl.valid;
            r_f_vld  <= r_p_vld;
            r_s_vld  <= r_f_vld;
            r_vld[0] <= r_s_vld;
            for (int k = 1; k <= RTW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_o_vld <= r_vld[RTW];
        end
    end

    assign o_valid     = r_o_vld;
    assign o_clearance = r_o_cl;
    assign o_region    = r_o_rgn;
    assign o_saturated = r_o_sat;

endmodule

`default_nettype wire

// ----- hw/rtl/capsule_sphere_clearance_core.sv -----
// Capsule-to-sphere clearance core. Each query beat gives a segment (base, axis, length), a
// sphere centre and two radii; one result beat returns distance minus both radii in signed
// fixed point, saturated with a flag, plus the clamp region. The core accepts one beat per
// cycle while no finished result is held. Its pipeline is the three projection stages, the
// load stage and 24 restoring divider stages of the projection parameter, three offset and
// square stages, the COORD_WIDTH + 6 stages of the square root (load plus one bit per stage)
// and the output stage. The whole pipeline holds while a result waits.
// depends on csc_pkg, csc_if, csc_proj, csc_div, csc_dist
`default_nettype none

module capsule_sphere_clearance_core #(
    parameter int COORD_WIDTH = csc_pkg::CSC_COORD_WIDTH,
    parameter int FRAC_BITS   = csc_pkg::CSC_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csc_in_if.sink    i_in,
    csc_out_if.source o_out
);
    import csc_pkg::*;

    logic                            en;
    t_stage_ctl                      proj_ctl, div_ctl, dist_ctl;
    logic signed [COORD_WIDTH-1:0]   in_base [3];
    logic signed [FRAC_BITS+1:0]     in_axis [3];
    logic signed [COORD_WIDTH-1:0]   in_point [3];

    logic                            pj_valid;
    logic signed [COORD_WIDTH+1:0]   pj_d [3];
    logic signed [COORD_WIDTH:0]     pj_v [3];
    logic signed [2*COORD_WIDTH+4:0] pj_dot, pj_dd;
    t_region                         pj_region;
    logic [COORD_WIDTH-2:0]          pj_ra, pj_rb;

    logic                            dv_valid;
    logic [CSC_LAMBDA_BITS-1:0]      dv_t;
    logic signed [COORD_WIDTH+1:0]   dv_d [3];
    logic signed [COORD_WIDTH:0]     dv_v [3];
    t_region                         dv_region;
    logic [COORD_WIDTH-2:0]          dv_ra, dv_rb;

    // pipeline advances unless a finished result is held, no beat taken in reset
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    assign proj_ctl = '{en: en, valid: i_in.valid};
    assign div_ctl  = '{en: en, valid: pj_valid};
    assign dist_ctl = '{en: en, valid: dv_valid};

    assign in_base  = '{i_in.base_x, i_in.base_y, i_in.base_z};
    assign in_axis  = '{i_in.axis_x, i_in.axis_y, i_in.axis_z};
    assign in_point = '{i_in.point_x, i_in.point_y, i_in.point_z};

    csc_proj #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (proj_ctl),
        .i_base   (in_base),
        .i_axis   (in_axis),
        .i_len    (i_in.axis_length),
        .i_point  (in_point),
        .i_ra     (i_in.radius_a),
        .i_rb     (i_in.radius_b),
        .o_valid  (pj_valid),
        .o_d      (pj_d),
        .o_v      (pj_v),
        .o_dot    (pj_dot),
        .o_dd     (pj_dd),
        .o_region (pj_region),
        .o_ra     (pj_ra),
        .o_rb     (pj_rb)
    );

    csc_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (div_ctl),
        .i_d      (pj_d),
        .i_v      (pj_v),
        .i_dot    (pj_dot),
        .i_dd     (pj_dd),
        .i_region (pj_region),
        .i_ra     (pj_ra),
        .i_rb     (pj_rb),
        .o_valid  (dv_valid),
        .o_t      (dv_t),
        .o_d      (dv_d),
        .o_v      (dv_v),
        .o_region (dv_region),
        .o_ra     (dv_ra),
        .o_rb     (dv_rb)
    );

    csc_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (dist_ctl),
        .i_t         (dv_t),
        .i_d         (dv_d),
        .i_v         (dv_v),
        .i_region    (dv_region),
        .i_ra        (dv_ra),
        .i_rb        (dv_rb),
        .o_valid     (o_out.valid),
        .o_clearance (o_out.clearance),
        .o_region    (o_out.region),
        .o_saturated (o_out.saturated)
    );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking bench for the capsule-to-sphere clearance core
// depends on csc_pkg, csc_if and capsule_sphere_clearance_core
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    localparam int CW = CSC_COORD_WIDTH;
    localparam int FB = CSC_FRAC_BITS;
    localparam int LB = CSC_LAMBDA_BITS;

    typedef struct packed {
        logic signed [CW-1:0] bx, by, bz;
        logic signed [FB+1:0] ax, ay, az;
        logic        [CW-2:0] len;
        logic signed [CW-1:0] px, py, pz;
        logic        [CW-2:0] ra, rb;
    } t_query;

    typedef struct packed {
        logic signed [CW-1:0] clearance;
        t_region              region;
        logic                 saturated;
    } t_clear;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csc_in_if  q_if ();
    csc_out_if r_if ();

    capsule_sphere_clearance_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (q_if.sink),
        .o_out   (r_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_query query_q[$];
    t_clear clear_q[$];
    int     n_err = 0;
    bit     stim_done = 1'b0;
    int     hold_cycles = 0;

    // floor division by a power of two
    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // expected clearance, region and saturation flag for one query
    function automatic t_clear clearance_of(t_query q);
        longint b[3], a[3], p[3], d[3], v[3], df[3];
        longint ln, dot, dd, span, cl;
        longint unsigned sq, rem, ud, t, m;
        t_clear r;
        b = '{q.bx, q.by, q.bz};
        a = '{q.ax, q.ay, q.az};
        p = '{q.px, q.py, q.pz};
        ln = longint'(q.len);
        dot = 0;
        dd = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = fshift(ln * a[i], FB);
            v[i] = p[i] - b[i];
            dot += v[i] * d[i];
            dd += d[i] * d[i];
        end
        if (ln == 0 || dd == 0 || dot <= 0) begin
            r.region = RGN_BASE;
            df = v;
        end else if (dot >= dd) begin
            r.region = RGN_END;
            for (int i = 0; i < 3; i++) df[i] = v[i] - d[i];
        end else begin
            r.region = RGN_INSIDE;
            rem = dot;
            ud = dd;
            t = 0;
            for (int i = 0; i < LB; i++) begin
                rem <<= 1;
                t <<= 1;
                if (rem >= ud) begin
                    rem -= ud;
                    t |= 1;
                end
            end
            for (int i = 0; i < 3; i++) df[i] = v[i] - fshift(d[i] * longint'(t), LB);
        end
        for (int i = 0; i < 3; i++) begin
            m = df[i] < 0 ? -df[i] : df[i];
            sq += m * m;
        end
        span = longint'(root64(sq));
        cl = span - longint'(q.ra) - longint'(q.rb);
        r.saturated = 1'b0;
        if (cl > (64'sd1 << (CW - 1)) - 1) begin
            cl = (64'sd1 << (CW - 1)) - 1;
            r.saturated = 1'b1;
        end else if (cl < -(64'sd1 << (CW - 1))) begin
            cl = -(64'sd1 << (CW - 1));
            r.saturated = 1'b1;
        end
        r.clearance = cl[CW-1:0];
        return r;
    endfunction

    function automatic logic [17:0] rand_axis(int mode);
        case (mode)
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom_range(0, 131071) - 65536);
            3: return 18'($urandom);
            default: return 18'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int sh;
        sh = $urandom_range(0, 7);
        q.bx = $signed(24'($urandom)) >>> sh;
        q.by = $signed(24'($urandom)) >>> sh;
        q.bz = $signed(24'($urandom)) >>> sh;
        q.px = $signed(24'($urandom)) >>> sh;
        q.py = $signed(24'($urandom)) >>> sh;
        q.pz = $signed(24'($urandom)) >>> sh;
        if ($urandom_range(0, 3) == 0) begin
            q.px = 24'(q.bx + $signed(24'($urandom_range(0, 2047))) - 1024);
            q.py = 24'(q.by + $signed(24'($urandom_range(0, 2047))) - 1024);
        end
        q.ax = rand_axis($urandom_range(0, 4));
        q.ay = rand_axis($urandom_range(0, 4));
        q.az = rand_axis($urandom_range(0, 4));
        q.len = ($urandom_range(0, 9) == 0) ? 23'd0 : 23'($urandom) >> $urandom_range(0, 6);
        q.ra = 23'($urandom) >> $urandom_range(0, 8);
        q.rb = 23'($urandom) >> $urandom_range(0, 8);
        return q;
    endfunction

    // directed corner queries, then random ones
    initial begin
        t_query q;
        q = '0;
        query_q.push_back(q);
        q.len = 23'h7fffff; q.ax = 18'sd65536; q.px = 24'sd65536 * 8;
        query_q.push_back(q);
        q.px = -24'sd65536;
        query_q.push_back(q);
        q.px = 24'h7fffff;
        query_q.push_back(q);
        q.bx = 24'h800000; q.by = 24'h800000; q.bz = 24'h800000;
        q.px = 24'h7fffff; q.py = 24'h7fffff; q.pz = 24'h7fffff; q.len = '0;
        query_q.push_back(q);
        q.ra = 23'h7fffff; q.rb = 23'h7fffff;
        query_q.push_back(q);
        q = '0; q.ra = 23'h7fffff; q.rb = 23'h7fffff;
        query_q.push_back(q);
        q = '0; q.len = 23'd65536 * 4; q.ay = -18'sd65536; q.py = -24'sd65536 * 2;
        q.px = 24'sd65536 * 3;
        query_q.push_back(q);
        q.ay = 18'h1ffff; q.az = 18'h20000;
        query_q.push_back(q);
        q = '0; q.len = 23'd65536; q.px = 24'sd65536;
        query_q.push_back(q);
        q = '0; q.len = 23'd1; q.ax = 18'sd1; q.pz = 24'sd100;
        query_q.push_back(q);
        q = '0; q.len = 23'h7fffff; q.ax = 18'sd46341; q.ay = -18'sd46341;
        q.px = 24'sd300000; q.py = -24'sd100000; q.pz = 24'h7fffff;
        query_q.push_back(q);
        q = '0; q.len = 23'h155555; q.az = 18'h2aaaa; q.bz = 24'h555555; q.pz = 24'haaaaaa;
        q.ra = 23'h2aaaaa; q.rb = 23'h555555;
        query_q.push_back(q);
        for (int i = 0; i < 540; i++) query_q.push_back(rand_query());
    end

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_if.valid <= 1'b0;
            q_if.base_x <= '0; q_if.base_y <= '0; q_if.base_z <= '0;
            q_if.axis_x <= '0; q_if.axis_y <= '0; q_if.axis_z <= '0;
            q_if.axis_length <= '0;
            q_if.point_x <= '0; q_if.point_y <= '0; q_if.point_z <= '0;
            q_if.radius_a <= '0; q_if.radius_b <= '0;
        end else if (!q_if.valid || q_if.ready) begin
            if (q_if.valid) clear_q.push_back(clearance_of(t_query'({q_if.base_x,
                q_if.base_y, q_if.base_z, q_if.axis_x, q_if.axis_y, q_if.axis_z,
                q_if.axis_length, q_if.point_x, q_if.point_y, q_if.point_z,
                q_if.radius_a, q_if.radius_b})));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                q_if.valid <= 1'b0;
            end else if (query_q.size() == 0) begin
                q_if.valid <= 1'b0;
                stim_done <= 1'b1;
            end else begin
                t_query q;
                q = query_q.pop_front();
                {q_if.base_x, q_if.base_y, q_if.base_z, q_if.axis_x, q_if.axis_y,
                 q_if.axis_z, q_if.axis_length, q_if.point_x, q_if.point_y,
                 q_if.point_z, q_if.radius_a, q_if.radius_b} <= q;
                q_if.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // long receiver hold-off once, so the pipeline fills and stalls input
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_cycles = 400;
        while (hold_cycles > 0) begin
            @(posedge i_clk);
            hold_cycles = hold_cycles - 1;
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if.ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_cycles > 0) r_if.ready <= 1'b0;
            else if (stall_phase[9:8] == 2'd0) r_if.ready <= 1'b1;
            else r_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && r_if.valid && r_if.ready) begin
            if (clear_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10) $display("unexpected result beat %h", r_if.clearance);
            end else begin
                t_clear e;
                e = clear_q.pop_front();
                if (e.clearance !== r_if.clearance || e.region !== r_if.region
                    || e.saturated !== r_if.saturated) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("mismatch: exp cl=%h rg=%0d sat=%b got cl=%h rg=%0d sat=%b",
                                 e.clearance, e.region, e.saturated,
                                 r_if.clearance, r_if.region, r_if.saturated);
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && clear_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_err == 0 && clear_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/csc_pkg.sv
hw/rtl/csc_if.sv
hw/rtl/csc_proj.sv
hw/rtl/csc_div.sv
hw/rtl/csc_dist.sv
hw/rtl/capsule_sphere_clearance_core.sv
verif/tb_top.sv
